// ===== hw/rtl/gcm_pkg.sv =====
`timescale 1ns / 1ps

package gcm_pkg;

    localparam int N_ELEM     = 64;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int VAL_W      = 16;
    localparam int SUM_W      = 24;
    localparam int LAM_W      = 16;
    localparam int LAM_FRAC   = 8;
    localparam int PROD_W     = LAM_W + 1 + SUM_W;
    localparam int RES_W      = 48;
    localparam int KADDR_W    = 2 * IDX_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [2:0] CMD_LOAD_KERNEL = 3'd0;
    localparam logic [2:0] CMD_LOAD_MASTER = 3'd1;
    localparam logic [2:0] CMD_CLEAR       = 3'd2;
    localparam logic [2:0] CMD_ADD_ITEM    = 3'd3;
    localparam logic [2:0] CMD_GAIN        = 3'd4;
    localparam logic [2:0] CMD_EVALUATE    = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_N_USED         = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARE_MASTER   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_SELECTED = 2'd3;

    typedef struct packed {
        logic [2:0]              cmd;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
        logic [IDX_W-1:0]        item;
    } in_t;

    typedef struct packed {
        logic signed [RES_W-1:0] result;
        logic                    skipped;
    } out_t;

endpackage

// ===== hw/rtl/graph_cut_memoized_gain_unit.sv =====
`timescale 1ns / 1ps
// One kernel/sum memory read per cycle. One item at a time: s_ready is high only in the idle
// state, so a new command is taken only after the last one's result has left the done state;
// a result may wait in the output register. Reset (aresetn low, synchronous): state and
// configuration registers to their defaults, master and subset sums read as zero through
// per-entry valid bits, selection map cleared.
module graph_cut_memoized_gain_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [gcm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [gcm_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  gcm_pkg::in_t                         s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output gcm_pkg::out_t                        m_data
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_LD_RD = 4'd1;
    localparam logic [3:0] ST_LD_WR = 4'd2;
    localparam logic [3:0] ST_ADD   = 4'd3;
    localparam logic [3:0] ST_GAIN0 = 4'd4;
    localparam logic [3:0] ST_GAIN1 = 4'd5;
    localparam logic [3:0] ST_GAIN2 = 4'd6;
    localparam logic [3:0] ST_GAIN3 = 4'd7;
    localparam logic [3:0] ST_EVAL  = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;

    localparam int IW = gcm_pkg::IDX_W;
    localparam int CW = gcm_pkg::CNT_W;
    localparam int SW = gcm_pkg::SUM_W;
    localparam int RW = gcm_pkg::RES_W;
    localparam int PW = gcm_pkg::PROD_W;

    logic [3:0]  state_reg;
    logic [CW-1:0] n_used_reg;
    logic [gcm_pkg::LAM_W-1:0] lambda_reg;
    logic share_reg, check_reg;

    gcm_pkg::in_t cmd_reg;
    logic [CW-1:0] cnt_reg;
    logic pv1_reg, pv2_reg;
    logic [IW-1:0] rdq_reg;
    logic [gcm_pkg::N_ELEM-1:0] sel_reg, mvld_reg, svld_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [SW-1:0] m_reg;
    logic signed [gcm_pkg::VAL_W-1:0] k_reg;
    logic signed [RW-1:0] acc_reg;
    logic skip_reg;
    logic m_valid_reg;
    gcm_pkg::out_t m_data_reg;

    logic [CW-1:0] n_eff;
    logic [IW-1:0] rd_addr;
    logic [gcm_pkg::KADDR_W-1:0] k_raddr;
    logic k_we, m_we, s_we;
    logic [SW-1:0] m_rdata, s_rdata, m_wdata, s_wdata;
    logic [gcm_pkg::VAL_W-1:0] k_rdata;
    logic signed [SW-1:0] m_eff, s_eff;
    logic signed [SW-1:0] mul_b;
    logic signed [PW-1:0] mul_w;
    logic item_ok, issue;

    assign n_eff   = (n_used_reg > CW'(gcm_pkg::N_ELEM)) ? CW'(gcm_pkg::N_ELEM) : n_used_reg;
    assign item_ok = {1'b0, s_data.item} < n_eff;
    assign issue   = cnt_reg < n_eff;

    always_comb begin
        rd_addr = cmd_reg.item;
        if (state_reg == ST_LD_RD) begin
            rd_addr = cmd_reg.col;
        end else if (state_reg == ST_ADD || state_reg == ST_EVAL) begin
            rd_addr = cnt_reg[IW-1:0];
        end
    end

    assign k_raddr = (state_reg == ST_ADD) ? {cnt_reg[IW-1:0], cmd_reg.item}
                                           : {cmd_reg.item, cmd_reg.item};
    assign k_we    = (state_reg == ST_LD_RD) && (cmd_reg.cmd == gcm_pkg::CMD_LOAD_KERNEL);

    // Master entries never written since reset, and subset entries never written since reset or clear, read as zero
    assign m_eff = mvld_reg[rdq_reg] ? $signed(m_rdata) : '0;
    assign s_eff = svld_reg[rdq_reg] ? $signed(s_rdata) : '0;

    assign m_we    = (state_reg == ST_LD_WR);
    assign m_wdata = m_eff + SW'(cmd_reg.value);
    assign s_we    = (state_reg == ST_ADD) && pv1_reg;
    assign s_wdata = s_eff + SW'($signed(k_rdata));

    assign mul_b = (state_reg == ST_GAIN2) ? SW'(k_reg) : s_eff;
    assign mul_w = $signed({1'b0, lambda_reg}) * mul_b;

    gcm_ram #(.WIDTH(gcm_pkg::VAL_W), .DEPTH(gcm_pkg::N_ELEM * gcm_pkg::N_ELEM)) u_kernel (
        .clk(aclk), .we(k_we), .waddr({cmd_reg.row, cmd_reg.col}),
        .wdata(cmd_reg.value), .raddr(k_raddr), .rdata(k_rdata)
    );

    gcm_ram #(.WIDTH(SW), .DEPTH(gcm_pkg::N_ELEM)) u_master (
        .clk(aclk), .we(m_we), .waddr(rdq_reg), .wdata(m_wdata),
        .raddr(rd_addr), .rdata(m_rdata)
    );

    gcm_ram #(.WIDTH(SW), .DEPTH(gcm_pkg::N_ELEM)) u_subset (
        .clk(aclk), .we(s_we), .waddr(rdq_reg), .wdata(s_wdata),
        .raddr(rd_addr), .rdata(s_rdata)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        rdq_reg <= rd_addr;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            n_used_reg  <= CW'(64);
            lambda_reg  <= 16'd256;
            share_reg   <= 1'b1;
            check_reg   <= 1'b1;
            sel_reg     <= '0;
            mvld_reg    <= '0;
            svld_reg    <= '0;
            pv1_reg     <= 1'b0;
            pv2_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    gcm_pkg::CFG_N_USED:         n_used_reg <= cfg_data[CW-1:0];
                    gcm_pkg::CFG_LAMBDA:         lambda_reg <= cfg_data;
                    gcm_pkg::CFG_SHARE_MASTER:   share_reg  <= cfg_data[0];
                    gcm_pkg::CFG_CHECK_SELECTED: check_reg  <= cfg_data[0];
                    default: ;
                endcase
            end
            if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    cnt_reg <= '0;
                    pv1_reg <= 1'b0;
                    pv2_reg <= 1'b0;
                    if (s_valid) begin
                        cmd_reg  <= s_data;
                        acc_reg  <= '0;
                        unique case (s_data.cmd) inside
                            gcm_pkg::CMD_LOAD_KERNEL, gcm_pkg::CMD_LOAD_MASTER: begin
                                skip_reg  <= 1'b0;
                                state_reg <= ST_LD_RD;
                            end
                            gcm_pkg::CMD_CLEAR: begin
                                skip_reg  <= 1'b0;
                                sel_reg   <= '0;
                                svld_reg  <= '0;
                                state_reg <= ST_DONE;
                            end
                            gcm_pkg::CMD_ADD_ITEM: begin
                                if (!item_ok || sel_reg[s_data.item]) begin
                                    skip_reg  <= 1'b1;
                                    state_reg <= ST_DONE;
                                end else begin
                                    skip_reg  <= 1'b0;
                                    state_reg <= ST_ADD;
                                end
                            end
                            gcm_pkg::CMD_GAIN: begin
                                if (!item_ok || (check_reg && sel_reg[s_data.item])) begin
                                    skip_reg  <= 1'b1;
                                    state_reg <= ST_DONE;
                                end else begin
                                    skip_reg  <= 1'b0;
                                    state_reg <= ST_GAIN0;
                                end
                            end
                            gcm_pkg::CMD_EVALUATE: begin
                                skip_reg  <= 1'b0;
                                state_reg <= ST_EVAL;
                            end
                            default: begin
                                skip_reg  <= 1'b0;
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_LD_RD: begin
                    // kernel written this cycle; master read in flight
                    if (cmd_reg.cmd == gcm_pkg::CMD_LOAD_MASTER || share_reg) begin
                        state_reg <= ST_LD_WR;
                    end else begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_LD_WR: begin
                    mvld_reg[rdq_reg] <= 1'b1;
                    state_reg <= ST_DONE;
                end
                ST_ADD: begin
                    pv1_reg <= issue;
                    if (issue) begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                    if (pv1_reg) begin
                        svld_reg[rdq_reg] <= 1'b1;
                    end
                    if (!issue && !pv1_reg) begin
                        sel_reg[cmd_reg.item] <= 1'b1;
                        state_reg <= ST_DONE;
                    end
                end
                ST_GAIN0: state_reg <= ST_GAIN1;
                ST_GAIN1: begin
                    prod_reg  <= mul_w;
                    m_reg     <= m_eff;
                    k_reg     <= $signed(k_rdata);
                    state_reg <= ST_GAIN2;
                end
                ST_GAIN2: begin
                    acc_reg   <= (RW'(m_reg) <<< gcm_pkg::LAM_FRAC) - (RW'(prod_reg) <<< 1);
                    prod_reg  <= mul_w;
                    state_reg <= ST_GAIN3;
                end
                ST_GAIN3: begin
                    acc_reg   <= acc_reg - RW'(prod_reg);
                    state_reg <= ST_DONE;
                end
                ST_EVAL: begin
                    pv1_reg <= issue;
                    if (issue) begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                    prod_reg <= mul_w;
                    m_reg    <= m_eff;
                    pv2_reg  <= pv1_reg && sel_reg[rdq_reg];
                    if (pv2_reg) begin
                        acc_reg <= acc_reg + (RW'(m_reg) <<< gcm_pkg::LAM_FRAC) - RW'(prod_reg);
                    end
                    if (!issue && !pv1_reg && !pv2_reg) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg.result  <= acc_reg;
                        m_data_reg.skipped <= skip_reg;
                        state_reg          <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== hw/rtl/gcm_ram.sv =====
`timescale 1ns / 1ps

module gcm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [gcm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [gcm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    gcm_pkg::in_t                   s_data = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    gcm_pkg::out_t                  m_data;

    graph_cut_memoized_gain_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // gain unit shadow state
    logic signed [gcm_pkg::VAL_W-1:0] sim_kernel [gcm_pkg::N_ELEM][gcm_pkg::N_ELEM];
    bit                               sim_written [gcm_pkg::N_ELEM][gcm_pkg::N_ELEM];
    logic signed [gcm_pkg::SUM_W-1:0] sim_master [gcm_pkg::N_ELEM];
    logic signed [gcm_pkg::SUM_W-1:0] sim_subset [gcm_pkg::N_ELEM];
    bit                               sim_sel [gcm_pkg::N_ELEM];
    int unsigned                      reg_n_used = 64;
    int unsigned                      reg_lambda = 256;
    bit                               reg_share = 1;
    bit                               reg_check = 1;

    gcm_pkg::out_t pending_results [$];
    int   errors = 0;
    bit   rx_hold = 0;

    function automatic int unsigned active_count();
        return reg_n_used < gcm_pkg::N_ELEM ? reg_n_used : gcm_pkg::N_ELEM;
    endfunction

    function automatic gcm_pkg::out_t predict_gain_step(gcm_pkg::in_t it);
        gcm_pkg::out_t o;
        int unsigned n;
        longint r;
        longint lam;
        o = '0;
        n = active_count();
        lam = longint'(reg_lambda);
        r = 0;
        case (it.cmd)
            gcm_pkg::CMD_LOAD_KERNEL: begin
                sim_kernel[it.row][it.col] = it.value;
                sim_written[it.row][it.col] = 1;
                if (reg_share) sim_master[it.col] = sim_master[it.col] + it.value;
            end
            gcm_pkg::CMD_LOAD_MASTER: sim_master[it.col] = sim_master[it.col] + it.value;
            gcm_pkg::CMD_CLEAR: begin
                foreach (sim_subset[e]) begin
                    sim_subset[e] = '0;
                    sim_sel[e] = 0;
                end
            end
            gcm_pkg::CMD_ADD_ITEM: begin
                if (it.item >= n || sim_sel[it.item]) begin
                    o.skipped = 1'b1;
                end else begin
                    for (int e = 0; e < n; e++)
                        sim_subset[e] = sim_subset[e] + sim_kernel[e][it.item];
                    sim_sel[it.item] = 1;
                end
            end
            gcm_pkg::CMD_GAIN: begin
                if (it.item >= n || (reg_check && sim_sel[it.item])) begin
                    o.skipped = 1'b1;
                end else begin
                    r = longint'(sim_master[it.item]) * 256
                        - 2 * lam * longint'(sim_subset[it.item])
                        - lam * longint'(sim_kernel[it.item][it.item]);
                end
            end
            gcm_pkg::CMD_EVALUATE: begin
                for (int e = 0; e < n; e++)
                    if (sim_sel[e])
                        r += longint'(sim_master[e]) * 256 - lam * longint'(sim_subset[e]);
            end
            default: ;
        endcase
        o.result = r[gcm_pkg::RES_W-1:0];
        return o;
    endfunction

    // reads of unwritten entries must never happen
    function automatic bit column_ready(int unsigned col);
        int unsigned n;
        n = active_count();
        for (int e = 0; e < n; e++)
            if (!sim_written[e][col]) return 0;
        return 1;
    endfunction

    function automatic bit all_ready();
        int unsigned n;
        n = active_count();
        for (int e = 0; e < n; e++)
            if (sim_sel[e] && !sim_written[e][e]) return 0;
        return 1;
    endfunction

    function automatic int unsigned gap_len();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // valid stays high after a transfer only until the next item or an idle stretch
    task automatic send_cmd(gcm_pkg::in_t it);
        int unsigned g;
        g = gap_len();
        if (g != 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        pending_results.push_back(predict_gain_step(it));
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        int unsigned w;
        w = 0;
        s_valid <= 1'b0;
        while (pending_results.size() != 0 && w < 200000) begin
            @(posedge aclk);
            w++;
        end
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_reg(logic [gcm_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[gcm_pkg::CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            gcm_pkg::CFG_N_USED:       reg_n_used = val & 7'h7f;
            gcm_pkg::CFG_LAMBDA:       reg_lambda = val & 16'hffff;
            gcm_pkg::CFG_SHARE_MASTER: reg_share  = val & 1;
            default:                   reg_check  = val & 1;
        endcase
    endtask

    function automatic gcm_pkg::in_t mk(logic [2:0] c, int unsigned r, int unsigned cl,
                                        int v, int unsigned itm);
        gcm_pkg::in_t it;
        it.cmd = c;
        it.row = r[gcm_pkg::IDX_W-1:0];
        it.col = cl[gcm_pkg::IDX_W-1:0];
        it.value = v[gcm_pkg::VAL_W-1:0];
        it.item = itm[gcm_pkg::IDX_W-1:0];
        return it;
    endfunction

    function automatic bool_full_col(int unsigned c);
        return 0;
    endfunction

    // full columns 0, 7 and 63 plus the diagonal; entry (3,3) is loaded later
    task automatic test_kernel_load();
        for (int r = 0; r < gcm_pkg::N_ELEM; r++)
            for (int c = 0; c < gcm_pkg::N_ELEM; c++) begin
                int v;
                v = $urandom_range(0, 65535) - 32768;
                if (r == 0 && c == 0) v = 32767;
                if (r == 1 && c == 1) v = -32768;
                if ((c == 0 || c == 7 || c == 63 || r == c) && !(r == 3 && c == 3))
                    send_cmd(mk(gcm_pkg::CMD_LOAD_KERNEL, r, c, v, $urandom_range(0, 63)));
            end
    endtask

    task automatic test_directed();
        send_cmd(mk(gcm_pkg::CMD_LOAD_MASTER, 63, 5, -32768, 0));
        send_cmd(mk(gcm_pkg::CMD_LOAD_MASTER, 0, 0, 32767, 63));
        send_cmd(mk(gcm_pkg::CMD_GAIN, 0, 0, 0, 0));
        send_cmd(mk(gcm_pkg::CMD_ADD_ITEM, 0, 0, 0, 0));
        send_cmd(mk(gcm_pkg::CMD_ADD_ITEM, 0, 0, 0, 0));
        send_cmd(mk(gcm_pkg::CMD_GAIN, 0, 0, 0, 0));
        send_cmd(mk(gcm_pkg::CMD_ADD_ITEM, 0, 0, 0, 63));
        send_cmd(mk(gcm_pkg::CMD_GAIN, 0, 0, 0, 1));
        send_cmd(mk(gcm_pkg::CMD_EVALUATE, 0, 0, 0, 0));
        send_cmd(mk(3'd6, 63, 63, -1, 63));
        send_cmd(mk(3'd7, 0, 0, 0, 0));
        send_cmd(mk(gcm_pkg::CMD_CLEAR, 0, 0, 0, 0));
        send_cmd(mk(gcm_pkg::CMD_EVALUATE, 0, 0, 0, 0));
    endtask

    task automatic test_config_extremes();
        write_reg(gcm_pkg::CFG_CHECK_SELECTED, 0);
        write_reg(gcm_pkg::CFG_LAMBDA, 65535);
        send_cmd(mk(gcm_pkg::CMD_ADD_ITEM, 0, 0, 0, 7));
        send_cmd(mk(gcm_pkg::CMD_GAIN, 0, 0, 0, 7));
        send_cmd(mk(gcm_pkg::CMD_EVALUATE, 0, 0, 0, 0));
        write_reg(gcm_pkg::CFG_N_USED, 1);
        send_cmd(mk(gcm_pkg::CMD_GAIN, 0, 0, 0, 1));
        send_cmd(mk(gcm_pkg::CMD_ADD_ITEM, 0, 0, 0, 0));
        send_cmd(mk(gcm_pkg::CMD_EVALUATE, 0, 0, 0, 0));
        write_reg(gcm_pkg::CFG_N_USED, 0);
        send_cmd(mk(gcm_pkg::CMD_GAIN, 0, 0, 0, 0));
        send_cmd(mk(gcm_pkg::CMD_ADD_ITEM, 0, 0, 0, 0));
        send_cmd(mk(gcm_pkg::CMD_EVALUATE, 0, 0, 0, 0));
        write_reg(gcm_pkg::CFG_N_USED, 127);
        write_reg(gcm_pkg::CFG_LAMBDA, 0);
        write_reg(gcm_pkg::CFG_SHARE_MASTER, 0);
        send_cmd(mk(gcm_pkg::CMD_LOAD_KERNEL, 3, 3, 1234, 0));
        send_cmd(mk(gcm_pkg::CMD_GAIN, 0, 0, 0, 3));
    endtask

    // greedy-style rounds: gains, add, evaluate, occasional clear, reloads and unknown commands
    task automatic random_rounds(int unsigned count);
        for (int i = 0; i < count; i++) begin
            int unsigned p;
            int unsigned q;
            gcm_pkg::in_t it;
            p = $urandom_range(0, 99);
            it = mk(gcm_pkg::CMD_GAIN, $urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom_range(0, 65535) - 32768, $urandom_range(0, 63));
            if (p < 40)      it.cmd = gcm_pkg::CMD_GAIN;
            else if (p < 58) it.cmd = gcm_pkg::CMD_ADD_ITEM;
            else if (p < 68) it.cmd = gcm_pkg::CMD_EVALUATE;
            else if (p < 72) it.cmd = gcm_pkg::CMD_CLEAR;
            else if (p < 82) it.cmd = gcm_pkg::CMD_LOAD_MASTER;
            else if (p < 92) it.cmd = gcm_pkg::CMD_LOAD_KERNEL;
            else             it.cmd = 3'($urandom_range(6, 7));
            // avoid rewriting kernel entries and reading unwritten ones
            if (it.cmd == gcm_pkg::CMD_LOAD_KERNEL && sim_written[it.row][it.col])
                it.cmd = gcm_pkg::CMD_LOAD_MASTER;
            if (it.cmd == gcm_pkg::CMD_ADD_ITEM && !column_ready(it.item)) begin
                q = $urandom_range(0, 2);
                it.item = (q == 0) ? 6'd0 : ((q == 1) ? 6'd7 : 6'd63);
            end
            if (it.cmd == gcm_pkg::CMD_GAIN && it.item < active_count()
                    && !sim_written[it.item][it.item]) it.cmd = gcm_pkg::CMD_LOAD_MASTER;
            if (it.cmd == gcm_pkg::CMD_EVALUATE && !all_ready()) it.cmd = gcm_pkg::CMD_CLEAR;
            send_cmd(it);
        end
    endtask

    task automatic test_random();
        write_reg(gcm_pkg::CFG_N_USED, 64);
        write_reg(gcm_pkg::CFG_LAMBDA, 256);
        write_reg(gcm_pkg::CFG_SHARE_MASTER, 1);
        write_reg(gcm_pkg::CFG_CHECK_SELECTED, 1);
        send_cmd(mk(gcm_pkg::CMD_CLEAR, 0, 0, 0, 0));
        random_rounds(130);
        write_reg(gcm_pkg::CFG_N_USED, $urandom_range(2, 63));
        write_reg(gcm_pkg::CFG_LAMBDA, $urandom_range(0, 65535));
        write_reg(gcm_pkg::CFG_CHECK_SELECTED, 0);
        random_rounds(110);
        write_reg(gcm_pkg::CFG_N_USED, 64);
        write_reg(gcm_pkg::CFG_LAMBDA, 1);
        write_reg(gcm_pkg::CFG_CHECK_SELECTED, 1);
        random_rounds(110);
    endtask

    task automatic test_backpressure();
        drain();
        rx_hold = 1;
        for (int i = 0; i < 6; i++)
            send_cmd(mk(gcm_pkg::CMD_GAIN, 0, 0, 0, $urandom_range(0, 63)));
    endtask

    // receiver: random stalls, with one long hold-off when requested
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_hold) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) < 70);
        end
    end

    initial begin
        wait (rx_hold);
        repeat (300) @(posedge aclk);
        rx_hold = 0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected transfer: actual result=%0d skipped=%0b",
                         $time, m_data.result, m_data.skipped);
                errors++;
            end else begin
                gcm_pkg::out_t want;
                want = pending_results.pop_front();
                if (want.result !== m_data.result)
                    begin
                        $display("%0t result mismatch: expected %0d actual %0d",
                                 $time, want.result, m_data.result);
                        errors++;
                    end
                if (want.skipped !== m_data.skipped) begin
                    $display("%0t skipped mismatch: expected %0b actual %0b",
                             $time, want.skipped, m_data.skipped);
                    errors++;
                end
            end
        end
    end

    initial begin
        foreach (sim_master[e]) begin
            sim_master[e] = '0;
            sim_subset[e] = '0;
            sim_sel[e] = 0;
            for (int c = 0; c < gcm_pkg::N_ELEM; c++) sim_written[e][c] = 0;
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);
        test_kernel_load();
        test_directed();
        test_config_extremes();
        test_random();
        test_backpressure();
        drain();
        if (errors == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
